@@ rtl/swamm_pkg.sv @@
// ----------------------------------------------------------------------------
// swamm_pkg
// Shared types and constants for the sliding-window mean/max/min block.
// ----------------------------------------------------------------------------
package swamm_pkg;

  localparam int WINDOW_MAX   = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int AXES         = 3;
  localparam int POS_W        = $clog2(WINDOW_MAX);
  localparam int LEN_W        = POS_W + 1;
  localparam int CFG_W        = 7;
  localparam int ENTRY_W      = AXES * SAMPLE_WIDTH;
  localparam int SUM_W        = SAMPLE_WIDTH + POS_W + 1;
  localparam int QUO_W        = SUM_W;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // Divider handshake between the top level and the divide unit
  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [LEN_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SUM_W-1:0]   quotient;
  } div_rsp_t;

endpackage

@@ rtl/sliding_window_avg_max_min_core.sv @@
// ----------------------------------------------------------------------------
// sliding_window_avg_max_min_core
// Windowed mean, maximum and minimum of three-axis samples over a ring RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/stall): one transaction carries sample_x/y/z.
//   Output channel (valid/stall): one transaction per input with the three
//   means and the six extremes. Config channel (valid/ready) writes
//   window_length; ready is high only while the block is idle or clearing the RAM.
//   One item at a time: the sample is written to the ring RAM, then the
//   newest L entries (L = window_length, 0 read as 1, above 64 as 64) are
//   read back one per cycle through the RAM's single read port, then three
//   sums are divided in turn by a bit-serial divider. A new sample is
//   taken only once the previous result has been written to the output
//   register, and the input stalls in between. The result sits in an
//   output register while the next item is already accepted.
//   Reset clears control state and starts a sweep that zeroes all 64
//   RAM entries; input stalls during the sweep, config writes are still taken.
//   A stalled result holds until taken; the next result waits for it.
// ----------------------------------------------------------------------------
module sliding_window_avg_max_min_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [swamm_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  swamm_pkg::sample_t                    sample_x,
  input  swamm_pkg::sample_t                    sample_y,
  input  swamm_pkg::sample_t                    sample_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output swamm_pkg::sample_t                    avg_x,
  output swamm_pkg::sample_t                    avg_y,
  output swamm_pkg::sample_t                    avg_z,
  output swamm_pkg::sample_t                    max_x,
  output swamm_pkg::sample_t                    min_x,
  output swamm_pkg::sample_t                    max_y,
  output swamm_pkg::sample_t                    min_y,
  output swamm_pkg::sample_t                    max_z,
  output swamm_pkg::sample_t                    min_z
);
  import swamm_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_PUT   = 3'd5;

  logic [2:0]         state;
  logic [CFG_W-1:0]   window_length;
  logic [POS_W-1:0]   newest;
  logic [POS_W-1:0]   clear_addr;
  logic [LEN_W-1:0]   eff_len;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   issued;
  logic [LEN_W-1:0]   got;
  logic               rd_pend;
  logic [POS_W-1:0]   rd_addr;
  logic               wr_en;
  logic [POS_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  logic [SUM_W-1:0]   sum [AXES];
  sample_t            hi [AXES];
  sample_t            lo [AXES];
  sample_t            quo [AXES];
  logic [1:0]         axis;
  div_req_t           dreq;
  div_rsp_t           drsp;
  logic               in_acc;

  // Clamp the configured length to 1..WINDOW_MAX
  always_comb begin
    if (window_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (CFG_W'(window_length) > CFG_W'(WINDOW_MAX)) begin
      eff_len = LEN_W'(WINDOW_MAX);
    end else begin
      eff_len = LEN_W'(window_length);
    end
  end

  assign cfg_ready = (state == ST_IDLE) || (state == ST_CLEAR);
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;

  // RAM write: clearing sweep or new sample at the next ring position
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clear_addr;
    wr_data = '0;
    if (state == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (in_acc) begin
      wr_en   = 1'b1;
      wr_addr = newest + 1'b1;
      wr_data = {sample_z, sample_y, sample_x};
    end
  end

  // Scan reads go backward from the newest entry
  assign rd_addr = newest - issued[POS_W-1:0];

  swamm_ram #(.WIDTH(ENTRY_W), .DEPTH(WINDOW_MAX)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    dreq.start    = (state == ST_DIV);
    dreq.dividend = sum[axis];
    dreq.divisor  = len;
  end

  swamm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Sequencer: clear, accept, scan, divide, present
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clear_addr    <= '0;
      window_length <= CFG_W'(1);
      newest        <= '0;
      out_valid     <= 1'b0;
      rd_pend       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_length <= cfg_data;
      end
      if (out_valid && !out_stall && (state != ST_PUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == POS_W'(WINDOW_MAX - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            newest <= newest + 1'b1;
            len    <= eff_len;
            issued <= '0;
            got    <= '0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_pend <= (issued != len);
          if (issued != len) begin
            issued <= issued + 1'b1;
          end
          if (rd_pend) begin
            for (int a = 0; a < AXES; a++) begin
              if (got == '0) begin
                sum[a] <= SUM_W'(sample_t'(rd_data[a*SAMPLE_WIDTH +: SAMPLE_WIDTH]));
                hi[a]  <= rd_data[a*SAMPLE_WIDTH +: SAMPLE_WIDTH];
                lo[a]  <= rd_data[a*SAMPLE_WIDTH +: SAMPLE_WIDTH];
              end else begin
                sum[a] <= sum[a]
                  + SUM_W'(sample_t'(rd_data[a*SAMPLE_WIDTH +: SAMPLE_WIDTH]));
                if (sample_t'(rd_data[a*SAMPLE_WIDTH +: SAMPLE_WIDTH]) > hi[a]) begin
                  hi[a] <= rd_data[a*SAMPLE_WIDTH +: SAMPLE_WIDTH];
                end
                if (sample_t'(rd_data[a*SAMPLE_WIDTH +: SAMPLE_WIDTH]) < lo[a]) begin
                  lo[a] <= rd_data[a*SAMPLE_WIDTH +: SAMPLE_WIDTH];
                end
              end
            end
            got <= got + 1'b1;
            if (got + 1'b1 == len) begin
              axis  <= '0;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (drsp.done) begin
            quo[axis] <= drsp.quotient[SAMPLE_WIDTH-1:0];
            if (axis == 2'(AXES - 1)) begin
              state <= ST_PUT;
            end else begin
              axis  <= axis + 1'b1;
              state <= ST_DIV;
            end
          end
        end
        ST_PUT: begin
          if (!out_valid || !out_stall) begin
            avg_x     <= quo[0];
            avg_y     <= quo[1];
            avg_z     <= quo[2];
            max_x     <= hi[0];
            min_x     <= lo[0];
            max_y     <= hi[1];
            min_y     <= lo[1];
            max_z     <= hi[2];
            min_z     <= lo[2];
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/swamm_ram.sv @@
// ----------------------------------------------------------------------------
// swamm_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module swamm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/swamm_div.sv @@
// ----------------------------------------------------------------------------
// swamm_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module swamm_div (
  input  logic                clk,
  input  logic                rst,
  input  swamm_pkg::div_req_t req,
  output swamm_pkg::div_rsp_t rsp
);
  import swamm_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] quo;
  logic [SUM_W-1:0] rem;
  logic [LEN_W-1:0] dvs;
  logic             neg;
  logic [SUM_W:0]   trial;
  logic [SUM_W-1:0] mag;

  assign mag   = req.dividend[SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;
  assign trial = {rem, quo[SUM_W-1]} - {{(SUM_W+1-LEN_W){1'b0}}, dvs};

  // Shift in one dividend bit per cycle, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(SUM_W);
        quo   <= mag;
        rem   <= '0;
        dvs   <= req.divisor;
        neg   <= req.dividend[SUM_W-1];
      end else if (busy) begin
        if (!trial[SUM_W]) begin
          rem <= trial[SUM_W-1:0];
          quo <= {quo[SUM_W-2:0], 1'b1};
        end else begin
          rem <= {rem[SUM_W-2:0], quo[SUM_W-1]};
          quo <= {quo[SUM_W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restore the sign of the quotient
  assign rsp = {done, (neg ? (~quo + 1'b1) : quo)};

endmodule

@@ rtl/swamm_checker.sv @@
// ----------------------------------------------------------------------------
// swamm_checker
// Port-level checks of the sliding-window block, bound to the top level.
// ----------------------------------------------------------------------------
module swamm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input swamm_pkg::sample_t avg_x,
  input swamm_pkg::sample_t max_x,
  input swamm_pkg::sample_t min_x
);
  import swamm_pkg::*;

  // Extremes are ordered
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (min_x <= max_x))
    else $error("min above max");

  // Mean lies between the extremes
  a_mean: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (avg_x >= min_x && avg_x <= max_x))
    else $error("mean outside extremes");

  // Accepting a sample stalls the input on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second sample taken during scan");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(avg_x)))
    else $error("stalled result changed");

  // Result follows an accepted sample, never at once
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_valid) |=> !out_valid)
    else $error("result too early");

endmodule

bind sliding_window_avg_max_min_core swamm_checker u_swamm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .avg_x     (avg_x),
  .max_x     (max_x),
  .min_x     (min_x)
);
